[src/assert_macros.svh]
// assertion macros used by the trade message field extractor
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tmfe_pkg.sv]
// shared types, constants and field helpers for the trade message field extractor
// no dependencies
package tmfe_pkg;

  // longest message kept; later bytes of an overlong message are ignored
  localparam int MAX_MESSAGE_BYTES = 44;
  // bytes that the record fields reach into (offsets 0..43)
  localparam int FRAME_BYTES = 44;
  // bytes actually stored: the smaller of the two
  localparam int BUF_BYTES = (MAX_MESSAGE_BYTES < FRAME_BYTES) ? MAX_MESSAGE_BYTES
                                                               : FRAME_BYTES;
  localparam int POS_W = $clog2(BUF_BYTES + 1);
  localparam int IDX_W = $clog2(BUF_BYTES);

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_Q     = 8'h51;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // config register select (paddr bit 3)
  typedef enum logic [0:0] {
    CFG_START_INDEX = 1'b0,
    CFG_END_INDEX   = 1'b1
  } cfg_reg_e;

  // one complete message, byte 0 is the type code
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // one result beat
  typedef struct packed {
    logic        status;
    logic [7:0]  type_code;
    logic [15:0] locate_id;
    logic [15:0] track_id;
    logic [47:0] timestamp;
    logic [63:0] order_id;
    logic        buy_side;
    logic [63:0] share_count;
    logic [63:0] stock_name;
    logic [31:0] price_raw;
    logic [63:0] trade_id;
    logic [7:0]  cross_kind;
  } rec_t;

  // big-endian reads at fixed offsets
  function automatic logic [15:0] be16(frame_t f, int first);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < 2; i++) v = {v[7:0], f[first+i]};
    return v;
  endfunction

  function automatic logic [31:0] be32(frame_t f, int first);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) v = {v[23:0], f[first+i]};
    return v;
  endfunction

  function automatic logic [47:0] be48(frame_t f, int first);
    logic [47:0] v;
    v = '0;
    for (int i = 0; i < 6; i++) v = {v[39:0], f[first+i]};
    return v;
  endfunction

  function automatic logic [63:0] be64(frame_t f, int first);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v = {v[55:0], f[first+i]};
    return v;
  endfunction

  // stock name with spaces squeezed out, packed from the top byte down
  function automatic logic [63:0] pack_name(frame_t f, int first);
    logic [7:0][7:0] v;
    logic [3:0]      k;
    v = '0;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (f[first+i] != CHAR_SPACE) begin
        v[3'(4'd7 - k)] = f[first+i];
        k = k + 4'd1;
      end
    end
    return v;
  endfunction

endpackage

[src/tmfe_decode.sv]
// field extraction for one captured message frame
// depends on tmfe_pkg
module tmfe_decode (
  input  tmfe_pkg::frame_t frame_i,
  input  logic             finished_i,
  output tmfe_pkg::rec_t   rec_o
);
  import tmfe_pkg::*;

  // type-specific layout, finished beats carry zeros
  always_comb begin
    rec_o = '0;
    if (finished_i) begin
      rec_o.status = 1'b1;
    end else begin
      rec_o.type_code  = frame_i[0];
      rec_o.locate_id  = be16(frame_i, 1);
      rec_o.track_id   = be16(frame_i, 3);
      rec_o.timestamp  = be48(frame_i, 5);
      rec_o.cross_kind = CHAR_SPACE;
      priority if (frame_i[0] == CHAR_P) begin
        rec_o.order_id    = be64(frame_i, 11);
        rec_o.buy_side    = (frame_i[19] == CHAR_B);
        rec_o.share_count = {32'd0, be32(frame_i, 20)};
        rec_o.stock_name  = pack_name(frame_i, 24);
        rec_o.price_raw   = be32(frame_i, 32);
        rec_o.trade_id    = be64(frame_i, 36);
      end else if (frame_i[0] == CHAR_Q) begin
        rec_o.share_count = be64(frame_i, 11);
        rec_o.stock_name  = pack_name(frame_i, 19);
        rec_o.price_raw   = be32(frame_i, 27);
        rec_o.trade_id    = be64(frame_i, 31);
        rec_o.cross_kind  = frame_i[39];
      end else begin
        // broken trade: match number only
        rec_o.trade_id = be64(frame_i, 11);
      end
    end
  end

endmodule

[src/trade_message_field_extractor.sv]
// Trade message field extractor: takes one feed byte per beat and, at the last byte of a
// P, Q or B message, gives one record (or a finished status once the message count has
// passed end_index). A byte is accepted every cycle as long as results are taken; a result
// beat goes through frame capture, then field decode into the output register, after its
// message's last byte. Messages of other types, or counted before start_index, give nothing.
// depends on tmfe_pkg, tmfe_decode and assert_macros.svh
`include "assert_macros.svh"

module trade_message_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  type_code_o,
  output logic [15:0] locate_id_o,
  output logic [15:0] track_id_o,
  output logic [47:0] timestamp_o,
  output logic [63:0] order_id_o,
  output logic        buy_side_o,
  output logic [63:0] share_count_o,
  output logic [63:0] stock_name_o,
  output logic [31:0] price_raw_o,
  output logic [63:0] trade_id_o,
  output logic [7:0]  cross_kind_o
);
  import tmfe_pkg::*;

  logic [63:0]                 start_q, end_q;
  logic [63:0]                 count_q, count_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [BUF_BYTES-1:0][7:0]   msg_buf_q;
  frame_t                      frame_d, frame_q;
  logic                        fin_d, fin_q;
  logic                        s1_valid_q, s1_valid_d;
  logic                        out_valid_q, out_valid_d;
  rec_t                        rec_d, out_q;
  logic                        cfg_wr, accept, s2_ready, s1_adv, emit, msg_end;
  logic                        type_ok, below, above, out_kind_ok;
  cfg_reg_e                    cfg_sel;

  // config registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        CFG_START_INDEX: start_q <= pwdata;
        CFG_END_INDEX:   end_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_START_INDEX: prdata = start_q;
      CFG_END_INDEX:   prdata = end_q;
      default:         prdata = '0;
    endcase
  end

  // pipeline handshake
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign msg_end    = accept && last_byte_i;

  // merge stored bytes with the incoming one, unreceived bytes read as zero
  always_comb begin
    frame_d = '0;
    for (int i = 0; i < BUF_BYTES; i++) begin
      if (pos_q == POS_W'(i)) begin
        frame_d[i] = data_byte_i;
      end else if (pos_q > POS_W'(i)) begin
        frame_d[i] = msg_buf_q[i];
      end
    end
  end

  // message filter and counting window
  assign type_ok = (frame_d[0] == CHAR_P) || (frame_d[0] == CHAR_Q) ||
                   (frame_d[0] == CHAR_B);
  assign below   = count_q < start_q;
  assign above   = count_q > end_q;
  assign emit    = msg_end && type_ok && !below;
  assign fin_d   = above;

  always_comb begin
    count_d = count_q;
    if (msg_end && type_ok && (below || !above)) begin
      count_d = count_q + 64'd1;
    end
  end

  // byte position, saturates once the buffer is full
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q < POS_W'(BUF_BYTES)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // stage valids
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pos_q       <= pos_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // message byte store
  always_ff @(posedge clk_i) begin
    if (accept && !last_byte_i && (pos_q < POS_W'(BUF_BYTES))) begin
      msg_buf_q[pos_q[IDX_W-1:0]] <= data_byte_i;
    end
  end

  // frame capture
  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_q <= frame_d;
      fin_q   <= fin_d;
    end
  end

  // field decode
  tmfe_decode u_decode (
    .frame_i   (frame_q),
    .finished_i(fin_q),
    .rec_o     (rec_d)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= rec_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign type_code_o   = out_q.type_code;
  assign locate_id_o   = out_q.locate_id;
  assign track_id_o    = out_q.track_id;
  assign timestamp_o   = out_q.timestamp;
  assign order_id_o    = out_q.order_id;
  assign buy_side_o    = out_q.buy_side;
  assign share_count_o = out_q.share_count;
  assign stock_name_o  = out_q.stock_name;
  assign price_raw_o   = out_q.price_raw;
  assign trade_id_o    = out_q.trade_id;
  assign cross_kind_o  = out_q.cross_kind;

  // record types that may leave the block
  assign out_kind_ok = (type_code_o == CHAR_P) || (type_code_o == CHAR_Q) ||
                       (type_code_o == CHAR_B);

  // checks
  `ASSERT_AT(a_pos_range, pos_q <= POS_W'(BUF_BYTES), "byte position past buffer")
  `ASSERT_NEXT(a_count_hold, !msg_end, $stable(count_q), "count moved mid-message")
  `ASSERT_AT(a_fin_zero, !(out_valid_o && status_o) || type_code_o == '0, "finished beat has data")
  `ASSERT_AT(a_rec_type, !(out_valid_o && !status_o) || out_kind_ok, "record with bad type")
  `ASSERT_AT(a_full_stall, !(s1_valid_q && !s2_ready) || !in_ready_o, "input taken while full")

endmodule
